/* rtl/core/nwom_pkg.sv */
`timescale 1ns / 1ps

package nwom_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int WD_W    = 3;
    localparam int OP_W    = 3;
    localparam int DAY_W   = 5;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_YEAR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_MONTH = 1'd1;

    // selector codes
    localparam logic [OP_W-1:0] OP_TEENTH = 3'd0;
    localparam logic [OP_W-1:0] OP_FOURTH = 3'd4;
    localparam logic [OP_W-1:0] OP_LAST   = 3'd5;

    localparam logic [WD_W-1:0] WD_SATURDAY = 3'd6;

    // floor(x / 25) == (x * RECIP25) >> RECIP25_SH for x below 43690
    localparam int RECIP25    = 5243;
    localparam int RECIP25_SH = 17;

    typedef logic [YEAR_W-1:0]  year_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [WD_W-1:0]    weekday_t;
    typedef logic [OP_W-1:0]    opcode_t;
    typedef logic [DAY_W-1:0]   day_t;

    // month index 0..11
    function automatic logic [2:0] month_offset(input logic [3:0] idx);
        logic [2:0] r;
        case (idx)
            4'd0:    r = 3'd0;
            4'd1:    r = 3'd3;
            4'd2:    r = 3'd2;
            4'd3:    r = 3'd5;
            4'd4:    r = 3'd0;
            4'd5:    r = 3'd3;
            4'd6:    r = 3'd5;
            4'd7:    r = 3'd1;
            4'd8:    r = 3'd4;
            4'd9:    r = 3'd6;
            4'd10:   r = 3'd2;
            4'd11:   r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic day_t month_days(input logic [3:0] idx, input logic leap);
        day_t r;
        case (idx)
            4'd1:                    r = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: r = 5'd30;
            default:                 r = 5'd31;
        endcase
        return r;
    endfunction

    // 8 == 1 mod 7, so folding octal digits keeps the residue
    function automatic logic [2:0] mod7(input logic [15:0] v);
        logic [5:0] s;
        logic [3:0] t;
        s = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
          + 6'(v[15]);
        t = 4'(s[2:0]) + 4'(s[5:3]);
        if (t >= 4'd7) begin
            t = t - 4'd7;
        end
        return t[2:0];
    endfunction

endpackage

/* rtl/core/nth_weekday_of_month_date.sv */
`timescale 1ns / 1ps

// Nth weekday of a month in the proleptic Gregorian calendar. Write the year
// (index 0) and month (index 1) on the cfg port, then stream requests: each
// item carries a weekday (0 Sunday .. 6 Saturday) in s_tdata and a selector in
// s_tuser (0 the day from 13 to 19, 1..4 the nth occurrence, 5 or above the
// last one). Each request yields one day of the month on m_tdata. The block
// is a four-stage pipeline (input register, year quotients, weekday of the
// first and month length, result register) that takes one item per cycle
// unless a waiting result holds it back; stages with no item keep filling
// while the output waits. Weekday code 7 counts as Sunday, month 0 as January
// and months above 12 as December.
module nth_weekday_of_month_date (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [nwom_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [nwom_pkg::YEAR_W-1:0]      cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [2:0] weekday
    input  logic [2:0]                       s_tuser,   // [2:0] opcode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata    // [4:0] day_of_month
);
    import nwom_pkg::*;

    year_t  cal_year_reg;
    month_t cal_month_reg;

    logic en1, en2, en3, en4;

    logic     v1_reg, v2_reg, v3_reg, v4_reg;
    weekday_t wd1_reg, wd2_reg, wd3_reg;
    opcode_t  op1_reg, op2_reg, op3_reg;

    logic [14:0] yy2_reg;
    logic [7:0]  q100_2_reg;
    logic [5:0]  q400_2_reg;
    logic [3:0]  midx2_reg;
    year_t       y2_reg;
    logic [9:0]  yq25_2_reg;

    logic [2:0]  w1_3_reg;
    day_t        len3_reg;

    day_t        day_reg;

    weekday_t    wd_in;
    opcode_t     op_in;

    month_t      m_clamp;
    logic [3:0]  midx_next;
    logic [14:0] yy_next;
    logic [25:0] p100;
    logic [23:0] p400;
    logic [26:0] p25;

    logic [15:0] sum3;
    year_t       r25;
    logic        leap;
    logic [2:0]  w1_next;
    day_t        len_next;

    logic [2:0]  w13, wl;
    day_t        day_next;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_year_reg  <= YEAR_W'(2000);
            cal_month_reg <= MONTH_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_CAL_YEAR:  cal_year_reg  <= cfg_wdata;
                CFG_CAL_MONTH: cal_month_reg <= cfg_wdata[MONTH_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage moves when it is empty or the next one moves
    assign en4 = !v4_reg || m_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // stage 1: input register
    always_comb begin
        wd_in = s_tdata[WD_W-1:0];
        if (wd_in == 3'd7) begin
            wd_in = '0;
        end
        op_in = s_tuser;
        if (op_in > OP_LAST) begin
            op_in = OP_LAST;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            wd1_reg <= wd_in;
            op1_reg <= op_in;
        end
    end

    // stage 2: shifted year and its quotients by 100 and 400, and the year's quotient by 25
    always_comb begin
        m_clamp = cal_month_reg;
        if (m_clamp == '0) begin
            m_clamp = MONTH_W'(1);
        end else if (m_clamp > MONTH_W'(12)) begin
            m_clamp = MONTH_W'(12);
        end
        midx_next = m_clamp - 4'd1;
        // january and february belong to the previous year
        yy_next = 15'(cal_year_reg) + 15'd400 - ((m_clamp < 4'd3) ? 15'd1 : 15'd0);
        p100 = 26'(yy_next[14:2]) * 26'(RECIP25);
        p400 = 24'(yy_next[14:4]) * 24'(RECIP25);
        p25  = 27'(cal_year_reg) * 27'(RECIP25);
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            wd2_reg    <= wd1_reg;
            op2_reg    <= op1_reg;
            yy2_reg    <= yy_next;
            q100_2_reg <= p100[RECIP25_SH+7:RECIP25_SH];
            q400_2_reg <= p400[RECIP25_SH+5:RECIP25_SH];
            midx2_reg  <= midx_next;
            y2_reg     <= cal_year_reg;
            yq25_2_reg <= p25[RECIP25_SH+9:RECIP25_SH];
        end
    end

    // stage 3: weekday of day 1 and month length
    always_comb begin
        sum3 = 16'(yy2_reg) + 16'(yy2_reg[14:2]) - 16'(q100_2_reg) + 16'(q400_2_reg)
             + 16'(month_offset(midx2_reg)) + 16'd1;
        w1_next = mod7(sum3);
        r25 = y2_reg - YEAR_W'(yq25_2_reg) * YEAR_W'(25);
        // by 4, and either not by 25 or by 16 (with 25 that makes 400)
        leap = (y2_reg[1:0] == 2'd0) && ((r25 != '0) || (y2_reg[3:0] == 4'd0));
        len_next = month_days(midx2_reg, leap);
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            wd3_reg  <= wd2_reg;
            op3_reg  <= op2_reg;
            w1_3_reg <= w1_next;
            len3_reg <= len_next;
        end
    end

    // stage 4: matching day
    always_comb begin
        w13 = mod7(16'(w1_3_reg) + 16'd5);
        wl  = mod7(16'(w1_3_reg) + 16'(len3_reg) - 16'd1);
        day_next = '0;
        case (op3_reg)
            OP_TEENTH: begin
                day_next = 5'd13 + 5'(mod7(16'(wd3_reg) + 16'd7 - 16'(w13)));
            end
            OP_LAST: begin
                day_next = len3_reg - 5'(mod7(16'(wl) + 16'd7 - 16'(wd3_reg)));
            end
            default: begin
                day_next = 5'd1 + 5'(mod7(16'(wd3_reg) + 16'd7 - 16'(w1_3_reg)))
                         + 5'd7 * 5'(op3_reg - 3'd1);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            day_reg <= day_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {3'd0, day_reg};

endmodule

/* rtl/core/nwom_chk.sv */
`timescale 1ns / 1ps

module nwom_chk (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a waiting result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a day is 1..31 and the padding is zero
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4:0] != 5'd0) && (m_tdata[7:5] == 3'd0))
        else $error("day out of range");

    // input only stalls behind a waiting result
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // an accepted item is valid at the output after the stage registers when m_tready stays high in between
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("item lost in pipeline");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind nth_weekday_of_month_date nwom_chk u_nwom_chk (.*);
